### rtl/core/rcm_pkg.sv
package rcm_pkg;

  localparam int PULSE_W = 12;
  localparam int STEP_W  = 15;
  localparam int FS_W    = 20;
  localparam int CMD_W   = 16;
  localparam int SP_W    = 21;
  localparam int ACT_W   = 3;

  localparam logic [16:0] OOR_MARGIN_US = 17'd500;
  localparam logic [31:0] FAILSAFE_MS   = 32'd300;
  localparam logic [11:0] DEFAULT_SPAN  = 12'd1000;

  localparam logic [2:0] REG_PULSE_MIN  = 3'd0;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd1;
  localparam logic [2:0] REG_RAMP_STEP  = 3'd2;
  localparam logic [2:0] REG_MODE       = 3'd3;
  localparam logic [2:0] REG_MAX_DUTY   = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd5;
  localparam logic [2:0] REG_MAX_MOTOR  = 3'd6;
  localparam logic [2:0] REG_MAX_BRAKE  = 3'd7;

  localparam logic [1:0] MODE_DUTY    = 2'd0;
  localparam logic [1:0] MODE_SPEED   = 2'd1;
  localparam logic [1:0] MODE_CURRENT = 2'd2;

  localparam logic [ACT_W-1:0] ACT_STOP    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DUTY    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SPEED   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CURRENT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BRAKE   = 3'd4;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_STOP = 1'b1;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min_us;
    logic [PULSE_W-1:0] pulse_max_us;
    logic [STEP_W-1:0]  ramp_step;
    logic [1:0]         control_mode;
    logic [STEP_W-1:0]  max_duty;
    logic [FS_W-1:0]    max_speed;
    logic [FS_W-1:0]    max_motor_current;
    logic [FS_W-1:0]    max_brake_current;
  } cfg_t;

  // classified word passed from front to back
  typedef struct packed {
    logic               op;
    logic               neg;
    logic [PULSE_W-1:0] mag;
    logic [PULSE_W-1:0] span;
  } word_t;

endpackage

### rtl/core/rcm_front.sv
module rcm_front
  import rcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pulse_width_us,
  input  logic [31:0] time_ms,
  input  logic        q_full,
  output logic        q_push,
  output word_t       q_word
);

  logic [31:0] last_valid_time;
  logic        failsafe_latched;

  logic               accept;
  logic               pulse_ok;
  logic               timeout;
  logic [16:0]        p_ext;
  logic [31:0]        elapsed;
  logic signed [12:0] raw_span;
  logic [11:0]        span;
  logic signed [17:0] n_raw;
  logic signed [17:0] n_clamp;
  logic signed [17:0] span_s;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    p_ext    = {1'b0, pulse_width_us};
    pulse_ok = ((p_ext + OOR_MARGIN_US) > {5'd0, cfg.pulse_min_us}) &&
               (p_ext < ({5'd0, cfg.pulse_max_us} + OOR_MARGIN_US));
    elapsed  = time_ms - last_valid_time;
    timeout  = elapsed > FAILSAFE_MS;
    raw_span = $signed({1'b0, cfg.pulse_max_us}) - $signed({1'b0, cfg.pulse_min_us});
    span     = (raw_span < 13'sd2) ? DEFAULT_SPAN : raw_span[11:0];
    span_s   = $signed({6'd0, span});
    n_raw    = $signed({1'b0, pulse_width_us, 1'b0})
             - $signed({6'd0, cfg.pulse_min_us})
             - $signed({6'd0, cfg.pulse_max_us});
    priority if (n_raw > span_s) begin
      n_clamp = span_s;
    end else if (n_raw < -span_s) begin
      n_clamp = -span_s;
    end else begin
      n_clamp = n_raw;
    end
    q_word.op   = pulse_ok ? OP_CMD : OP_STOP;
    q_word.neg  = n_clamp < 18'sd0;
    q_word.mag  = q_word.neg ? 12'(-n_clamp) : n_clamp[11:0];
    q_word.span = span;
    q_push      = accept && (pulse_ok || (timeout && !failsafe_latched));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid_time  <= '0;
      failsafe_latched <= 1'b0;
    end else if (accept) begin
      if (pulse_ok) begin
        last_valid_time  <= time_ms;
        failsafe_latched <= 1'b0;
      end else if (timeout) begin
        failsafe_latched <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/rcm_fifo.sv
module rcm_fifo
  import rcm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t push_word,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output word_t pop_word
);

  word_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/rcm_back.sv
module rcm_back
  import rcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   q_empty,
  input  word_t                  q_word,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ACT_W-1:0]       action,
  output logic signed [SP_W-1:0] setpoint,
  output logic signed [CMD_W-1:0] smoothed_command
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RAMP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]              state;
  logic signed [CMD_W-1:0] ramped_command;

  logic [17:0]      rem;
  logic [15:0]      dvd_low;
  logic [17:0]      divisor;
  logic [15:0]      quot;
  logic [3:0]       cnt;
  logic             neg;
  logic [15:0]      mag;
  logic [FS_W-1:0]  scale;
  logic             sp_neg;
  logic [ACT_W-1:0] act;
  logic [35:0]      prod;

  logic [16:0]        t20;
  logic [16:0]        span19;
  logic [16:0]        numer;
  logic [32:0]        dividend;
  logic [18:0]        trial;
  logic               take;
  logic signed [16:0] target;
  logic signed [17:0] diff;
  logic signed [17:0] step_s;
  logic signed [16:0] ramp_next;
  logic [36:0]        rounded;
  logic [SP_W-1:0]    sp_mag;
  logic               out_free;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    t20      = 17'(q_word.mag) * 17'd20;
    span19   = 17'(q_word.span) * 17'd19;
    numer    = t20 - 17'(q_word.span);
    dividend = {numer, 16'd0} + 33'(span19);
    trial    = {rem, dvd_low[15]};
    take     = trial >= {1'b0, divisor};
    if (neg) begin
      target = -$signed({1'b0, quot});
    end else begin
      target = (quot > 16'd32767) ? 17'sd32767 : $signed({1'b0, quot});
    end
    diff   = 18'(target) - 18'(ramped_command);
    step_s = $signed({3'd0, cfg.ramp_step});
    priority if (diff > step_s) begin
      ramp_next = 17'(ramped_command) + 17'(step_s);
    end else if (diff < -step_s) begin
      ramp_next = 17'(ramped_command) - 17'(step_s);
    end else begin
      ramp_next = target;
    end
    rounded = {1'b0, prod} + 37'd16384;
    sp_mag  = rounded[SP_W+14:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ramped_command <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_word.op == OP_STOP) begin
              ramped_command <= '0;
              act            <= ACT_STOP;
              prod           <= '0;
              sp_neg         <= 1'b0;
              state          <= S_OUT;
            end else begin
              neg <= q_word.neg;
              if (t20 < 17'(q_word.span)) begin
                quot  <= '0;
                state <= S_RAMP;
              end else begin
                rem     <= {1'b0, dividend[32:16]};
                dvd_low <= dividend[15:0];
                divisor <= 18'(q_word.span) * 18'd38;
                quot    <= '0;
                cnt     <= '0;
                state   <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          rem     <= take ? 18'(trial - {1'b0, divisor}) : trial[17:0];
          quot    <= {quot[14:0], take};
          dvd_low <= {dvd_low[14:0], 1'b0};
          cnt     <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_RAMP;
          end
        end
        S_RAMP: begin
          ramped_command <= ramp_next[15:0];
          mag            <= ramp_next[16] ? 16'(-ramp_next) : ramp_next[15:0];
          priority if (cfg.control_mode == MODE_DUTY) begin
            act    <= ACT_DUTY;
            scale  <= FS_W'(cfg.max_duty);
            sp_neg <= ramp_next[16];
          end else if (cfg.control_mode == MODE_SPEED) begin
            act    <= ACT_SPEED;
            scale  <= cfg.max_speed;
            sp_neg <= ramp_next[16];
          end else if (!ramp_next[16]) begin
            act    <= ACT_CURRENT;
            scale  <= cfg.max_motor_current;
            sp_neg <= 1'b0;
          end else begin
            act    <= ACT_BRAKE;
            scale  <= cfg.max_brake_current;
            sp_neg <= 1'b0;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 36'(mag) * 36'(scale);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            action           <= act;
            setpoint         <= sp_neg ? -$signed(sp_mag) : $signed(sp_mag);
            smoothed_command <= ramped_command;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/rc_pulse_command_mapper.sv
// channel  | signals                               | dir | notes
// input    | in_valid/in_ready, pulse_width_us,    | in  | one control tick per word
//          | time_ms                               |     |
// output   | out_valid/out_ready, action,          | out | zero or one word per tick
//          | setpoint, smoothed_command            |     |
// config   | psel/penable/pwrite/paddr/pwdata/     | in  | 8 regs at 4*i, pready tied high
//          | prdata/pready                         |     |
//
// Front classifies a tick in the cycle it is taken and queues it (2 deep).
// Back: a command word runs the restoring divider loop, then the ramp, multiply
// and output states; the deadzone skips the divider, a stop word goes straight
// to output, where a stall holds it. Invalid ticks with no word stay in the front.
// Synchronous reset restores register defaults and clears command state.
module rc_pulse_command_mapper
  import rcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             pulse_width_us,
  input  logic [31:0]             time_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ACT_W-1:0]        action,
  output logic signed [SP_W-1:0]  setpoint,
  output logic signed [CMD_W-1:0] smoothed_command
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  word_t push_word;
  word_t pop_word;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min_us      <= 12'd1000;
      cfg.pulse_max_us      <= 12'd2000;
      cfg.ramp_step         <= 15'd131;
      cfg.control_mode      <= MODE_CURRENT;
      cfg.max_duty          <= 15'd31129;
      cfg.max_speed         <= 20'd50000;
      cfg.max_motor_current <= 20'd60000;
      cfg.max_brake_current <= 20'd60000;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_PULSE_MIN: cfg.pulse_min_us      <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAX: cfg.pulse_max_us      <= pwdata[PULSE_W-1:0];
        REG_RAMP_STEP: cfg.ramp_step         <= pwdata[STEP_W-1:0];
        REG_MODE:      cfg.control_mode      <= pwdata[1:0];
        REG_MAX_DUTY:  cfg.max_duty          <= pwdata[STEP_W-1:0];
        REG_MAX_SPEED: cfg.max_speed         <= pwdata[FS_W-1:0];
        REG_MAX_MOTOR: cfg.max_motor_current <= pwdata[FS_W-1:0];
        REG_MAX_BRAKE: cfg.max_brake_current <= pwdata[FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PULSE_MIN: prdata = 32'(cfg.pulse_min_us);
      REG_PULSE_MAX: prdata = 32'(cfg.pulse_max_us);
      REG_RAMP_STEP: prdata = 32'(cfg.ramp_step);
      REG_MODE:      prdata = 32'(cfg.control_mode);
      REG_MAX_DUTY:  prdata = 32'(cfg.max_duty);
      REG_MAX_SPEED: prdata = 32'(cfg.max_speed);
      REG_MAX_MOTOR: prdata = 32'(cfg.max_motor_current);
      REG_MAX_BRAKE: prdata = 32'(cfg.max_brake_current);
      default:       prdata = '0;
    endcase
  end

  rcm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pulse_width_us (pulse_width_us),
    .time_ms        (time_ms),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_word         (push_word)
  );

  rcm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_word  (pop_word)
  );

  rcm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_word           (pop_word),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .setpoint         (setpoint),
    .smoothed_command (smoothed_command)
  );

endmodule
